// ----- rtl/lpgs_pkg.sv -----
// Package for the line position grid search block.
// Holds fixed field widths, Q1.12 constants, defaults and the queue status type.
// No dependencies.
package lpgs_pkg;

	// Field widths
	localparam int RW = 13;          // sensor reading, unsigned Q1.12
	localparam int PW = 13;          // position, signed Q1.12
	localparam int SW = 4;           // membership slope

	// Fixed point constants
	localparam int ONE_Q12 = 4096;
	localparam logic [SW-1:0] SLOPE_RESET = SW'(3);
	localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;

	// Defaults for top level parameters
	localparam int DEF_SENSORS = 16;
	localparam int DEF_CANDIDATES = 1024;

	// Frame queue depth and adder group size
	localparam int QUEUE_DEPTH = 2;
	localparam int GROUP = 8;

	// Frame queue status, seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/lpgs_front.sv -----
// Front end: accepts sensor items, saturates readings, collects a frame and
// pushes it with the previous position into the frame queue. Uses lpgs_pkg.
module lpgs_front
	import lpgs_pkg::*;
#(
	parameter int SENSORS = DEF_SENSORS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [RW-1:0]              sensor_value,
	input  logic signed [PW-1:0]       prior_line_pos,
	input  q_stat_t                    q_stat,
	output logic                       push,
	output logic [SENSORS*RW+PW-1:0]   push_data
);

	localparam int CW = $clog2(SENSORS);

	logic [CW-1:0] cnt_q;
	logic [RW-1:0] shift_q [SENSORS-1];
	logic [RW-1:0] r_sat;
	logic          last;
	logic          accept;

	// Readings above one saturate
	assign r_sat = (sensor_value > RW'(ONE_Q12)) ? RW'(ONE_Q12) : sensor_value;

	assign last     = (cnt_q == CW'(SENSORS - 1));
	assign in_ready = !(last && q_stat.full);
	assign accept   = in_valid && in_ready;
	assign push     = accept && last;

	// Item counter within a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last ? '0 : cnt_q + CW'(1);
		end
	end

	// Shift line of readings; oldest item of the frame ends at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q[SENSORS-2] <= r_sat;
			for (int k = 0; k < SENSORS - 2; k++) begin
				shift_q[k] <= shift_q[k+1];
			end
		end
	end

	// Frame word: readings low, previous position on top
	always_comb begin
		push_data = '0;
		for (int j = 0; j < SENSORS - 1; j++) begin
			push_data[j*RW +: RW] = shift_q[j];
		end
		push_data[(SENSORS-1)*RW +: RW] = r_sat;
		push_data[SENSORS*RW +: PW] = prior_line_pos;
	end

endmodule

// ----- rtl/lpgs_queue.sv -----
// Short frame queue between the front and the back end.
// Uses lpgs_pkg for depth and status type.
module lpgs_queue
	import lpgs_pkg::*;
#(
	parameter int DW = DEF_SENSORS * RW + PW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] head_data,
	output q_stat_t       q_stat
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [DW-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign head_data    = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == NW'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ----- rtl/lpgs_back.sv -----
// Back end: takes one frame from the queue and scores every candidate position
// through a five stage pipeline, one candidate per cycle. Uses lpgs_pkg.
module lpgs_back
	import lpgs_pkg::*;
#(
	parameter int SENSORS    = DEF_SENSORS,
	parameter int CANDIDATES = DEF_CANDIDATES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [SW-1:0]             slope,
	input  q_stat_t                   q_stat,
	input  logic [SENSORS*RW+PW-1:0]  head_data,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [PW-1:0]      position
);

	localparam int IW     = $clog2(CANDIDATES);
	localparam int RMW    = $clog2(CANDIDATES) + 1;
	localparam int Q_STEP = 8192 / CANDIDATES;
	localparam int R_STEP = 8192 % CANDIDATES;
	localparam int GROUPS = (SENSORS + GROUP - 1) / GROUP;
	localparam int SQW    = 25;
	localparam int GW     = SQW + $clog2(GROUP);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// Triangular membership, exact: max(0, 1 - slope*|d|)
	function automatic logic [RW-1:0] memb(input logic signed [PW:0] d,
		input logic [SW-1:0] s);
		logic [PW-1:0]    a;
		logic [PW+SW-1:0] p;
		a = d[PW] ? PW'(-d) : d[PW-1:0];
		p = (PW+SW)'(s) * (PW+SW)'(a);
		memb = (p >= (PW+SW)'(ONE_Q12)) ? '0 : RW'((PW+SW)'(ONE_Q12) - p);
	endfunction

	logic [1:0]              state_q;
	logic [IW-1:0]           idx_q;
	logic [PW-1:0]           num_q;
	logic [RMW-1:0]          rem_q;
	logic [RMW-1:0]          rem_sum;
	logic [SENSORS*RW-1:0]   frame_q;
	logic signed [PW-1:0]    prior_q;
	logic signed [PW-1:0]    cand;
	logic                    issue_v;
	logic                    issue_last;
	logic                    start;
	logic                    finish;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    last_s1, last_s2, last_s3, last_s4;
	logic signed [PW-1:0]    c_s1, c_s2, c_s3, c_s4;
	logic [RW-1:0]           mu_s1 [SENSORS];
	logic [RW-1:0]           mup_s1, mup_s2, mup_s3;
	logic [SQW-1:0]          sq_s2 [SENSORS];
	logic [GW-1:0]           grp_s3 [GROUPS];
	logic signed [31:0]      score_s4;

	logic signed [31:0]      best_score_q;
	logic signed [PW-1:0]    best_pos_q;
	logic                    better;
	logic                    out_valid_q;
	logic signed [PW-1:0]    position_q;

	assign start      = (state_q == ST_IDLE) && !q_stat.empty && !out_valid_q;
	assign pop        = start;
	assign issue_v    = (state_q == ST_ISSUE);
	assign issue_last = (idx_q == IW'(CANDIDATES - 1));
	// floor(i*8192/CANDIDATES) - 4096: subtracting half range flips the sign bit
	assign cand       = signed'(num_q ^ PW'(ONE_Q12));
	assign rem_sum    = rem_q + RMW'(R_STEP);
	assign finish     = v_s4 && last_s4;

	// Sequencer and candidate generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			num_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ISSUE;
						idx_q   <= '0;
						num_q   <= '0;
						rem_q   <= '0;
					end
				end
				ST_ISSUE: begin
					idx_q <= idx_q + IW'(1);
					if (rem_sum >= RMW'(CANDIDATES)) begin
						rem_q <= rem_sum - RMW'(CANDIDATES);
						num_q <= num_q + PW'(Q_STEP + 1);
					end else begin
						rem_q <= rem_sum;
						num_q <= num_q + PW'(Q_STEP);
					end
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Frame copy taken from the queue head
	always_ff @(posedge clk) begin
		if (start) begin
			frame_q <= head_data[SENSORS*RW-1:0];
			prior_q <= signed'(head_data[SENSORS*RW +: PW]);
		end
	end

	// Pipeline valid and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= issue_last;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		c_s1    <= cand;
		c_s2    <= c_s1;
		c_s3    <= c_s2;
		c_s4    <= c_s3;
		mup_s1  <= memb({cand[PW-1], cand} - {prior_q[PW-1], prior_q}, slope);
		mup_s2  <= mup_s1;
		mup_s3  <= mup_s2;
	end

	// Stages 1 and 2: membership per sensor lane, then squared error
	for (genvar j = 0; j < SENSORS; j++) begin : g_lane
		localparam logic signed [PW-1:0] SPOS = PW'((j * 8192) / SENSORS - ONE_Q12);
		logic [RW-1:0]        r;
		logic signed [RW:0]   e;
		logic [RW-1:0]        ae;
		logic [2*RW-1:0]      sq;

		assign r  = frame_q[j*RW +: RW];
		assign e  = signed'({1'b0, r}) - signed'({1'b0, mu_s1[j]});
		assign ae = e[RW] ? RW'(-e) : e[RW-1:0];
		assign sq = (2*RW)'(ae) * (2*RW)'(ae);

		always_ff @(posedge clk) begin
			mu_s1[j] <= memb({cand[PW-1], cand} - {SPOS[PW-1], SPOS}, slope);
			sq_s2[j] <= sq[SQW-1:0];
		end
	end

	// Stage 3: group sums of squared errors
	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			logic [GW-1:0] acc;
			acc = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < SENSORS) begin
					acc = acc + GW'(sq_s2[g*GROUP+k]);
				end
			end
			grp_s3[g] <= acc;
		end
	end

	// Stage 4: total minus prior membership scaled to Q.24
	always_ff @(posedge clk) begin
		logic [31:0] tot;
		tot = '0;
		for (int g = 0; g < GROUPS; g++) begin
			tot = tot + 32'(grp_s3[g]);
		end
		score_s4 <= signed'(tot) - signed'(32'(mup_s3) << 12);
	end

	// Stage 5: running minimum, first lowest wins
	assign better = v_s4 && (score_s4 < best_score_q);

	always_ff @(posedge clk) begin
		if (start) begin
			best_score_q <= SCORE_MAX;
			best_pos_q   <= '0;
		end else if (better) begin
			best_score_q <= score_s4;
			best_pos_q   <= c_s4;
		end
		if (finish) begin
			position_q <= better ? c_s4 : best_pos_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;

endmodule

// ----- rtl/line_position_grid_search_core.sv -----
// Top level of the line position grid search block.
// Instantiates lpgs_front, lpgs_queue and lpgs_back; uses lpgs_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, sensor_value, prior_line_pos) takes one
//   sensor reading per item; SENSORS items make a frame, counted internally.
//   prior_line_pos is taken from the last item of the frame only.
//   Output channel (out_valid/out_ready, position) gives one best candidate
//   position per frame, signed Q1.12.
//   cfg_we/cfg_wdata write membership_slope (reset 3) while the block is idle.
// Timing:
//   The back end scores one candidate per cycle in a five stage pipeline, so
//   with an idle back end out_valid rises once the last candidate of the frame
//   has passed the running minimum in stage 5. The back scores one frame at a
//   time: it starts the next queued frame only once the previous result has
//   been taken.
//   The front keeps accepting the next frames into a two frame queue while the
//   back works; it stalls only on the last item of a frame when the queue is
//   full. A stalled receiver holds the result in the output register and the
//   back starts no new frame until it is taken.
// Reset: arst_n clears the item count, queue, sequencer and output valid.
module line_position_grid_search_core
	import lpgs_pkg::*;
#(
	parameter int SENSORS    = DEF_SENSORS,
	parameter int CANDIDATES = DEF_CANDIDATES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RW-1:0]        sensor_value,
	input  logic signed [PW-1:0] prior_line_pos,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [PW-1:0] position,
	input  logic                 cfg_we,
	input  logic [SW-1:0]        cfg_wdata
);

	localparam int DW = SENSORS * RW + PW;

	logic [SW-1:0] membership_slope_q;
	q_stat_t       q_stat;
	logic          push;
	logic          pop;
	logic [DW-1:0] push_data;
	logic [DW-1:0] head_data;

	// Slope register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membership_slope_q <= SLOPE_RESET;
		end else if (cfg_we) begin
			membership_slope_q <= cfg_wdata;
		end
	end

	lpgs_front #(
		.SENSORS (SENSORS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sensor_value   (sensor_value),
		.prior_line_pos (prior_line_pos),
		.q_stat         (q_stat),
		.push           (push),
		.push_data      (push_data)
	);

	lpgs_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.q_stat    (q_stat)
	);

	lpgs_back #(
		.SENSORS    (SENSORS),
		.CANDIDATES (CANDIDATES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.slope     (membership_slope_q),
		.q_stat    (q_stat),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position)
	);

endmodule

// ----- rtl/lpgs_checker.sv -----
// Port level checker for line_position_grid_search_core, with its bind.
// Tracks frames in flight from the ports; uses lpgs_pkg.
module lpgs_checker
	import lpgs_pkg::*;
#(
	parameter int SENSORS = DEF_SENSORS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [PW-1:0] position
);

	localparam int CW = $clog2(SENSORS);

	logic [CW-1:0] cnt_q;
	logic [2:0]    pending_q;
	logic          in_acc;
	logic          out_acc;
	logic          frame_done;

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid && out_ready;
	assign frame_done = in_acc && (cnt_q == CW'(SENSORS - 1));

	// Frames completed at the input whose results are not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pending_q <= '0;
		end else begin
			if (in_acc) begin
				cnt_q <= (cnt_q == CW'(SENSORS - 1)) ? '0 : cnt_q + CW'(1);
			end
			if (frame_done && !out_acc) begin
				pending_q <= pending_q + 3'd1;
			end else if (out_acc && !frame_done) begin
				pending_q <= pending_q - 3'd1;
			end
		end
	end

	// A held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position))
		else $error("result changed while stalled");

	// No result without a completed frame
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without a completed frame");

	// Input stalls only with frames backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pending_q >= 3'd2)
		else $error("input stalled with no frames in flight");

	// Queue, back end and output register bound the frames in flight
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many frames in flight");

endmodule

bind line_position_grid_search_core lpgs_checker #(
	.SENSORS (SENSORS)
) u_lpgs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.position  (position)
);
